// File: rtl/tds_pkg.sv
// shared types and constants for the trap dispatch sequencer
package tds_pkg;

  typedef enum logic [1:0] {
    OP_EXEC  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [15:0] W_TST      = 16'h4A6D;
  localparam logic [15:0] W_BNE      = 16'h66FA;
  localparam logic [15:0] W_BKPT     = 16'h484F;
  localparam logic [15:0] W_TB_BASE  = 16'hA800;
  localparam logic [15:0] W_TB_NOPOP = 16'hAC00;
  localparam logic [15:0] W_UNIMPL   = 16'hA89F;
  localparam logic [7:0]  OS_ARGTRAP = 8'hF6;
  localparam logic [31:0] OS_TABLE   = 32'd1024;
  localparam logic [31:0] TB_TABLE   = 32'd3072;

  // memory command from sequencer to memory
  typedef struct packed {
    logic        en;
    logic        we;
    logic [31:0] addr;
    logic [15:0] wdata;
  } mem_cmd_t;

endpackage

// File: rtl/tds_mem.sv
// single-port word memory; read data is registered and valid in the cycle after the access
module tds_mem #(
  parameter int MEM_WORDS = 32768
) (
  input  logic              clk,
  input  tds_pkg::mem_cmd_t cmd,
  output logic [15:0]       rdata
);
  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [AW-1:0] idx;

  // byte address drops bit 0, index wraps modulo 2**AW (the depth when MEM_WORDS is a power of two)
  assign idx = cmd.addr[AW:1];

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      if (cmd.we) begin
        mem[idx] <= cmd.wdata;
      end
      rdata <= mem[idx];
    end
  end
endmodule

// File: rtl/tds_seq.sv
// sequencer: at most one word access per cycle against the memory
module tds_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [15:0]       in_opcode,
  input  logic [31:0]       in_stack_pointer,
  input  logic [31:0]       in_program_counter,
  input  logic [31:0]       in_data_one,
  input  logic [31:0]       in_data_two,
  input  logic [31:0]       in_addr_zero,
  input  logic [31:0]       in_addr_one,
  input  logic [15:0]       in_mem_address,
  input  logic [15:0]       in_mem_write_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_handled,
  output logic              out_interrupt_request,
  output logic [31:0]       out_new_stack_pointer,
  output logic [31:0]       out_new_program_counter,
  output logic [31:0]       out_new_data_one,
  output logic [31:0]       out_new_data_two,
  output logic [31:0]       out_new_addr_zero,
  output logic [31:0]       out_new_addr_one,
  output logic [15:0]       out_mem_read_data,
  output tds_pkg::mem_cmd_t cmd,
  input  logic [15:0]       rdata
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_LAST = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  // step kinds of the micro sequence
  typedef enum logic [1:0] {
    K_TB = 2'd0,
    K_OS = 2'd1,
    K_BK = 2'd2,
    K_RD = 2'd3
  } kind_t;

  state_t      state_r, state_nxt;
  kind_t       kind_r, kind_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        abf_r, abf_nxt;
  logic        pend_r, pend_nxt;      // a read was issued last cycle
  logic [4:0]  pstep_r, pstep_nxt;    // step of that read
  logic [15:0] w_r, w_nxt;
  logic [31:0] sp_r, sp_nxt, pc_r, pc_nxt, d1_r, d1_nxt, d2_r, d2_nxt;
  logic [31:0] a0_r, a0_nxt, a1_r, a1_nxt, pc2_r, pc2_nxt, sp0_r, sp0_nxt;
  logic [31:0] tg_r, tg_nxt, un_r, un_nxt, arg_r, arg_nxt;
  logic [15:0] sv_r, sv_nxt, rd_r, rd_nxt;
  logic        hd_r, hd_nxt, irq_r, irq_nxt;
  logic        done;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_handled             = hd_r;
  assign out_interrupt_request   = irq_r;
  assign out_new_stack_pointer   = sp_r;
  assign out_new_program_counter = pc_r;
  assign out_new_data_one        = d1_r;
  assign out_new_data_two        = d2_r;
  assign out_new_addr_zero       = a0_r;
  assign out_new_addr_one        = a1_r;
  assign out_mem_read_data       = rd_r;

  always_comb begin
    state_nxt = state_r; kind_nxt = kind_r; step_nxt = step_r;
    abf_nxt = abf_r; pend_nxt = 1'b0; pstep_nxt = step_r;
    w_nxt = w_r; sp_nxt = sp_r; pc_nxt = pc_r; d1_nxt = d1_r; d2_nxt = d2_r;
    a0_nxt = a0_r; a1_nxt = a1_r; pc2_nxt = pc2_r; sp0_nxt = sp0_r;
    tg_nxt = tg_r; un_nxt = un_r; arg_nxt = arg_r; sv_nxt = sv_r; rd_nxt = rd_r;
    hd_nxt = hd_r; irq_nxt = irq_r;
    cmd = '0;
    done = 1'b0;

    // capture read data of the previous cycle's access
    if (pend_r) begin
      case (kind_r)
        K_RD: rd_nxt = rdata;
        K_TB: begin
          case (pstep_r)
            5'd0: tg_nxt[31:16] = rdata;
            5'd1: tg_nxt[15:0]  = rdata;
            5'd2: un_nxt[31:16] = rdata;
            5'd3: un_nxt[15:0]  = rdata;
            default: ;
          endcase
        end
        K_OS: begin
          case (pstep_r)
            5'd0: arg_nxt[31:16] = rdata;
            5'd1: arg_nxt[15:0]  = rdata;
            5'd2: tg_nxt[31:16]  = rdata;
            5'd3: tg_nxt[15:0]   = rdata;
            default: ;
          endcase
        end
        default: begin
          case (pstep_r)
            5'd0:  sv_nxt         = rdata;
            5'd1:  d1_nxt[31:16]  = rdata;
            5'd2:  d1_nxt[15:0]   = rdata;
            5'd3:  d2_nxt[31:16]  = rdata;
            5'd4:  d2_nxt[15:0]   = rdata;
            5'd5:  if (!sv_r[8]) a0_nxt[31:16] = rdata;
            5'd6:  if (!sv_r[8]) a0_nxt[15:0]  = rdata;
            5'd7:  a1_nxt[31:16]  = rdata;
            5'd8:  a1_nxt[15:0]   = rdata;
            5'd9:  pc_nxt[31:16]  = rdata;
            5'd10: pc_nxt[15:0]   = rdata;
            default: ;
          endcase
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          w_nxt = in_opcode; sp_nxt = in_stack_pointer; pc_nxt = in_program_counter;
          d1_nxt = in_data_one; d2_nxt = in_data_two; a0_nxt = in_addr_zero;
          a1_nxt = in_addr_one; pc2_nxt = in_program_counter + 32'd2;
          sp0_nxt = in_stack_pointer;
          hd_nxt = 1'b0; irq_nxt = 1'b0; rd_nxt = '0; step_nxt = '0;
          state_nxt = S_OUT;
          case (tds_pkg::op_t'(in_operation))
            tds_pkg::OP_WRITE: begin
              cmd.en = 1'b1; cmd.we = 1'b1;
              cmd.addr = {16'd0, in_mem_address}; cmd.wdata = in_mem_write_data;
            end
            tds_pkg::OP_READ: begin
              cmd.en = 1'b1; cmd.addr = {16'd0, in_mem_address};
              kind_nxt = K_RD; pend_nxt = 1'b1; pstep_nxt = '0; state_nxt = S_LAST;
            end
            tds_pkg::OP_EXEC: begin
              if (abf_r && in_opcode == tds_pkg::W_TST) begin
                irq_nxt = 1'b1;
              end else begin
                abf_nxt = (in_opcode == tds_pkg::W_BNE);
                if (in_opcode[15:12] == 4'hA) begin
                  hd_nxt = 1'b1; state_nxt = S_RUN;
                  kind_nxt = (in_opcode >= tds_pkg::W_TB_BASE) ? K_TB : K_OS;
                  // argument pop only for the one trap that takes it
                  if (in_opcode < tds_pkg::W_TB_BASE &&
                      in_opcode[7:0] != tds_pkg::OS_ARGTRAP) step_nxt = 5'd2;
                end else if (in_opcode == tds_pkg::W_BKPT) begin
                  hd_nxt = 1'b1; state_nxt = S_RUN; kind_nxt = K_BK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        step_nxt = step_r + 5'd1;
        cmd.en = 1'b1;
        case (kind_r)
          K_TB: begin
            case (step_r)
              5'd0: begin
                cmd.addr = tds_pkg::TB_TABLE + {20'd0, w_r[9:0], 2'b00};
                pend_nxt = 1'b1;
              end
              5'd1: begin
                cmd.addr = tds_pkg::TB_TABLE + {20'd0, w_r[9:0], 2'b10};
                pend_nxt = 1'b1;
              end
              5'd2: begin
                cmd.addr = tds_pkg::TB_TABLE + {20'd0, tds_pkg::W_UNIMPL[9:0], 2'b00};
                pend_nxt = 1'b1;
              end
              5'd3: begin
                cmd.addr = tds_pkg::TB_TABLE + {20'd0, tds_pkg::W_UNIMPL[9:0], 2'b10};
                pend_nxt = 1'b1;
              end
              5'd4: begin
                cmd.en = 1'b0;
                // low half of the unimplemented handler arrives this cycle
                if (tg_r == un_nxt) d1_nxt = {16'd0, w_r};
                pc_nxt = tg_r;
                if (w_r >= tds_pkg::W_TB_NOPOP) done = 1'b1;
                else sp_nxt = sp_r - 32'd4;
              end
              5'd5: begin cmd.we = 1'b1; cmd.addr = sp_r; cmd.wdata = pc2_r[31:16]; end
              default: begin
                cmd.we = 1'b1; cmd.addr = sp_r + 32'd2; cmd.wdata = pc2_r[15:0];
                done = 1'b1;
              end
            endcase
          end
          K_OS: begin
            case (step_r)
              5'd0: begin cmd.addr = sp_r;         pend_nxt = 1'b1; end
              5'd1: begin
                cmd.addr = sp_r + 32'd2; pend_nxt = 1'b1; sp_nxt = sp_r + 32'd4;
              end
              5'd2: begin
                cmd.addr = tds_pkg::OS_TABLE + {22'd0, w_r[7:0], 2'b00};
                pend_nxt = 1'b1;
              end
              5'd3: begin
                cmd.addr = tds_pkg::OS_TABLE + {22'd0, w_r[7:0], 2'b10};
                pend_nxt = 1'b1;
              end
              // ten pushes: pc+2, a1, a0, d2, d1 high word at lower address; then trap word, bkpt, frame pointer
              5'd4:  begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd4;  cmd.wdata = pc2_r[31:16]; end
              5'd5:  begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd2;  cmd.wdata = pc2_r[15:0]; end
              5'd6:  begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd8;  cmd.wdata = a1_r[31:16]; end
              5'd7:  begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd6;  cmd.wdata = a1_r[15:0]; end
              5'd8:  begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd12; cmd.wdata = a0_r[31:16]; end
              5'd9:  begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd10; cmd.wdata = a0_r[15:0]; end
              5'd10: begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd16; cmd.wdata = d2_r[31:16]; end
              5'd11: begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd14; cmd.wdata = d2_r[15:0]; end
              5'd12: begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd20; cmd.wdata = d1_r[31:16]; end
              5'd13: begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd18; cmd.wdata = d1_r[15:0]; end
              5'd14: begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd22; cmd.wdata = w_r; end
              5'd15: begin cmd.we = 1'b1; cmd.addr = sp_r - 32'd24; cmd.wdata = tds_pkg::W_BKPT; end
              5'd16: begin
                cmd.we = 1'b1; cmd.addr = sp_r - 32'd28;
                sp0_nxt = sp_r - 32'd24;
                cmd.wdata = sp0_nxt[31:16];
              end
              default: begin
                cmd.we = 1'b1; cmd.addr = sp_r - 32'd26; cmd.wdata = sp0_r[15:0];
                sp_nxt = sp_r - 32'd28; d1_nxt = {16'd0, w_r}; pc_nxt = tg_r;
                if (w_r[7:0] == tds_pkg::OS_ARGTRAP) a0_nxt = arg_r;
                done = 1'b1;
              end
            endcase
          end
          default: begin
            // frame: bkpt, trap word, d1, d2, a0, a1, pc
            case (step_r)
              5'd0: cmd.addr = sp_r + 32'd2;
              5'd1: cmd.addr = sp_r + 32'd4;
              5'd2: cmd.addr = sp_r + 32'd6;
              5'd3: cmd.addr = sp_r + 32'd8;
              5'd4: cmd.addr = sp_r + 32'd10;
              5'd5: cmd.addr = sp_r + 32'd12;
              5'd6: cmd.addr = sp_r + 32'd14;
              5'd7: cmd.addr = sp_r + 32'd16;
              5'd8: cmd.addr = sp_r + 32'd18;
              5'd9: cmd.addr = sp_r + 32'd20;
              default: begin
                cmd.addr = sp_r + 32'd22;
                sp_nxt = sp_r + 32'd24;
                done = 1'b1;
              end
            endcase
            pend_nxt = 1'b1;
          end
        endcase
        if (done) state_nxt = pend_nxt ? S_LAST : S_OUT;
      end
      S_LAST: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      abf_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      abf_r   <= abf_nxt;
      pend_r  <= pend_nxt;
    end
    kind_r <= kind_nxt; step_r <= step_nxt; pstep_r <= pstep_nxt;
    w_r <= w_nxt; sp_r <= sp_nxt; pc_r <= pc_nxt; d1_r <= d1_nxt; d2_r <= d2_nxt;
    a0_r <= a0_nxt; a1_r <= a1_nxt; pc2_r <= pc2_nxt; sp0_r <= sp0_nxt;
    tg_r <= tg_nxt; un_r <= un_nxt; arg_r <= arg_nxt; sv_r <= sv_nxt; rd_r <= rd_nxt;
    hd_r <= hd_nxt; irq_r <= irq_nxt;
  end
endmodule

// File: rtl/trap_dispatch_sequencer_core.sv
// top level: sequencer plus local word memory
// one item at a time, paced by the single memory port, at most one word access a cycle
// synchronous active-low reset clears control and the branch flag; memory is
// not cleared and holds garbage until written
module trap_dispatch_sequencer_core #(
  parameter int MEM_WORDS = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_opcode,
  input  logic [31:0] in_stack_pointer,
  input  logic [31:0] in_program_counter,
  input  logic [31:0] in_data_one,
  input  logic [31:0] in_data_two,
  input  logic [31:0] in_addr_zero,
  input  logic [31:0] in_addr_one,
  input  logic [15:0] in_mem_address,
  input  logic [15:0] in_mem_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_handled,
  output logic        out_interrupt_request,
  output logic [31:0] out_new_stack_pointer,
  output logic [31:0] out_new_program_counter,
  output logic [31:0] out_new_data_one,
  output logic [31:0] out_new_data_two,
  output logic [31:0] out_new_addr_zero,
  output logic [31:0] out_new_addr_one,
  output logic [15:0] out_mem_read_data
);
  tds_pkg::mem_cmd_t cmd;
  logic [15:0] rdata;

  tds_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (.clk(clk), .cmd(cmd), .rdata(rdata));

  tds_seq u_seq (.*);
endmodule

// File: rtl/tds_checker.sv
// port-level checker bound to the top level
module tds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_handled,
  input logic        out_interrupt_request,
  input logic [15:0] out_mem_read_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result beat dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_handled && out_interrupt_request))
    else $error("handled and irq both set");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_handled || out_interrupt_request) |-> out_mem_read_data == 16'd0)
    else $error("read data on executed word");
endmodule

bind trap_dispatch_sequencer_core tds_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_handled(out_handled),
  .out_interrupt_request(out_interrupt_request),
  .out_mem_read_data(out_mem_read_data)
);
